// File: hw/rtl/lzfu_pkg.sv
// ----------------------------------------------------------------------------
// lzfu_pkg
// Types and constants shared by the flag/ULEB128 LZ decompressor modules.
// ----------------------------------------------------------------------------
package lzfu_pkg;

  localparam int unsigned HistoryDepthDef = 512;
  localparam int unsigned Lanes           = 8;
  localparam int unsigned MaxCopyLen      = 64 * Lanes;

  localparam logic [1:0] ErrNone  = 2'd0;
  localparam logic [1:0] ErrDist  = 2'd1;
  localparam logic [1:0] ErrUleb  = 2'd2;
  localparam logic [1:0] ErrTrunc = 2'd3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_last;
  } in_req_t;

  typedef struct packed {
    logic [63:0] data_word;
    logic [3:0]  byte_count;
    logic        run_last;
    logic        stream_done;
    logic [1:0]  error_code;
  } out_req_t;

  typedef enum logic [1:0] {
    CMD_LIT,
    CMD_COPY,
    CMD_CTRL
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] lit;
    logic [9:0] cp_dist;
    logic [9:0] len;
    logic       last;
    logic [1:0] err;
  } cmd_t;

  typedef enum logic {
    BK_IDLE,
    BK_COPY
  } back_state_e;

endpackage

// File: hw/rtl/lzfu_front.sv
// ----------------------------------------------------------------------------
// lzfu_front
// Parses flag bytes and ULEB128 fields, checks tokens, issues commands.
// ----------------------------------------------------------------------------
module lzfu_front #(
  parameter int unsigned HISTORY_DEPTH = lzfu_pkg::HistoryDepthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  lzfu_pkg::in_req_t in_req_i,
  input  logic              q_full_i,
  output logic              push_o,
  output lzfu_pkg::cmd_t    cmd_o
);
  import lzfu_pkg::*;

  logic [7:0] flag_q, flag_d;
  logic [3:0] slot_q, slot_d;
  logic [1:0] phase_q, phase_d;
  logic [6:0] acc_q, acc_d;
  logic       group_q, group_d;
  logic [9:0] dist_q, dist_d;
  logic [9:0] prod_q, prod_d;
  logic       hold_q, hold_d;

  logic        accept, cmd_valid, fail, adv, restart, have;
  logic [1:0]  ferr, ph_eff;
  logic [6:0]  payload;
  logic        more, last;
  logic [10:0] value, psum;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign push_o     = accept && cmd_valid;
  assign payload    = in_req_i.in_byte[6:0];
  assign more       = in_req_i.in_byte[7];
  assign last       = in_req_i.stream_last;
  assign ph_eff     = (phase_q == 2'd0) ? 2'd1 : phase_q;
  assign value      = group_q ? ({1'b0, payload[2:0], acc_q} + 11'd1)
                              : ({4'b0, payload} + 11'd1);
  assign psum       = {1'b0, prod_q} + value;

  always_comb begin
    flag_d = flag_q; slot_d = slot_q; phase_d = phase_q; acc_d = acc_q;
    group_d = group_q; dist_d = dist_q; prod_d = prod_q; hold_d = hold_q;
    cmd_o = '0; cmd_o.kind = CMD_CTRL; cmd_valid = 1'b0;
    fail = 1'b0; ferr = ErrNone; adv = 1'b0; restart = 1'b0; have = 1'b0;
    if (hold_q) begin
      if (last) begin
        cmd_valid = 1'b1; cmd_o.last = 1'b1; restart = 1'b1;
      end
    end else if (slot_q == 4'd0) begin
      flag_d = in_req_i.in_byte; slot_d = 4'd8; phase_d = 2'd0;
      if (last) begin
        fail = 1'b1; ferr = ErrTrunc;
      end
    end else if (phase_q == 2'd0 && !flag_q[0]) begin
      cmd_valid = 1'b1; cmd_o.kind = CMD_LIT; cmd_o.lit = in_req_i.in_byte;
      cmd_o.last = last; adv = 1'b1; restart = last;
      prod_d = (prod_q >= 10'(HISTORY_DEPTH)) ? prod_q : prod_q + 10'd1;
    end else begin
      phase_d = ph_eff;
      if (!group_q) begin
        acc_d = payload;
        if (more) begin
          group_d = 1'b1;
          if (last) begin
            fail = 1'b1; ferr = ErrTrunc;
          end
        end else begin
          have = 1'b1;
        end
      end else if (more || payload > 7'd7) begin
        fail = 1'b1; ferr = ErrUleb;
      end else begin
        have = 1'b1;
      end
      if (have) begin
        group_d = 1'b0;
        if (ph_eff == 2'd1) begin
          if (value > {1'b0, prod_q}) begin
            fail = 1'b1; ferr = ErrDist;
          end else begin
            dist_d = value[9:0]; phase_d = 2'd2;
            if (last) begin
              fail = 1'b1; ferr = ErrTrunc;
            end
          end
        end else if (value > 11'(MaxCopyLen)) begin
          fail = 1'b1; ferr = ErrUleb;
        end else begin
          cmd_valid = 1'b1; cmd_o.kind = CMD_COPY; cmd_o.cp_dist = dist_q;
          cmd_o.len = value[9:0]; cmd_o.last = last;
          adv = 1'b1; restart = last;
          prod_d = (psum >= 11'(HISTORY_DEPTH)) ? 10'(HISTORY_DEPTH) : psum[9:0];
        end
      end
    end
    if (adv) begin
      phase_d = 2'd0; flag_d = {1'b0, flag_q[7:1]}; slot_d = slot_q - 4'd1;
    end
    if (fail) begin
      cmd_valid = 1'b1; cmd_o.kind = CMD_CTRL; cmd_o.err = ferr; cmd_o.last = last;
      if (last) restart = 1'b1;
      else hold_d = 1'b1;
    end
    if (restart) begin
      flag_d = '0; slot_d = '0; phase_d = '0; acc_d = '0; group_d = 1'b0;
      dist_d = '0; prod_d = '0; hold_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= '0; slot_q <= '0; phase_q <= '0; acc_q <= '0; group_q <= 1'b0;
      dist_q <= '0; prod_q <= '0; hold_q <= 1'b0;
    end else if (accept) begin
      flag_q <= flag_d; slot_q <= slot_d; phase_q <= phase_d; acc_q <= acc_d;
      group_q <= group_d; dist_q <= dist_d; prod_q <= prod_d; hold_q <= hold_d;
    end
  end

endmodule

// File: hw/rtl/lzfu_queue.sv
// ----------------------------------------------------------------------------
// lzfu_queue
// Two-entry command queue between the parser and the copy engine.
// ----------------------------------------------------------------------------
module lzfu_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lzfu_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output lzfu_pkg::cmd_t cmd_o
);
  import lzfu_pkg::*;

  cmd_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign cmd_o   = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

// File: hw/rtl/lzfu_back.sv
// ----------------------------------------------------------------------------
// lzfu_back
// Executes commands: writes history, runs copies, packs output words.
// ----------------------------------------------------------------------------
module lzfu_back #(
  parameter int unsigned HISTORY_DEPTH = lzfu_pkg::HistoryDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  lzfu_pkg::cmd_t     cmd_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lzfu_pkg::out_req_t out_req_o
);
  import lzfu_pkg::*;

  localparam int unsigned PW = $clog2(HISTORY_DEPTH);

  logic [7:0] mem [HISTORY_DEPTH];

  back_state_e state_q, state_d;
  logic [PW-1:0] wptr_q, wptr_d, rptr_q, rptr_d, waddr;
  logic [9:0]  remain_q, remain_d;
  logic        pend_q, pend_d, last_q, last_d, ov_q, ov_d;
  logic [7:0]  rd_q, wdata;
  logic [63:0] word_q, word_d, word_nx;
  logic [2:0]  cnt_q, cnt_d;
  out_req_t    out_q, out_d;
  logic        en, we, re, fin;
  logic [10:0] wext, start;

  function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
    return (p == PW'(HISTORY_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign en          = !ov_q || !out_stall_i;
  assign pop_o       = en && (state_q == BK_IDLE) && q_valid_i;
  assign out_valid_o = ov_q;
  assign out_req_o   = out_q;
  assign wext        = 11'(wptr_q);
  assign start       = (wext >= {1'b0, cmd_i.cp_dist}) ? wext - {1'b0, cmd_i.cp_dist}
                                                       : wext + 11'(HISTORY_DEPTH)
                                                         - {1'b0, cmd_i.cp_dist};
  assign fin         = pend_q && (remain_q == 10'd0);
  assign word_nx     = word_q | ({56'b0, rd_q} << {cnt_q, 3'b000});

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: if (pop_o && cmd_i.kind == CMD_COPY) state_d = BK_COPY;
      BK_COPY: if (en && fin) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    wptr_d = wptr_q; rptr_d = rptr_q; remain_d = remain_q; pend_d = pend_q;
    last_d = last_q; word_d = word_q; cnt_d = cnt_q;
    ov_d = en ? 1'b0 : ov_q; out_d = out_q;
    we = 1'b0; waddr = wptr_q; wdata = rd_q; re = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (pop_o) begin
          case (cmd_i.kind)
            CMD_LIT: begin
              we = 1'b1; wdata = cmd_i.lit;
              wptr_d = cmd_i.last ? '0 : inc(wptr_q);
              ov_d = 1'b1;
              out_d = '{data_word: {56'b0, cmd_i.lit}, byte_count: 4'd1, run_last: 1'b1,
                        stream_done: cmd_i.last, error_code: ErrNone};
            end
            CMD_COPY: begin
              rptr_d = start[PW-1:0]; remain_d = cmd_i.len; pend_d = 1'b0;
              last_d = cmd_i.last; word_d = '0; cnt_d = '0;
            end
            default: begin
              ov_d = 1'b1;
              out_d = '{data_word: '0, byte_count: 4'd0, run_last: 1'b1,
                        stream_done: cmd_i.last, error_code: cmd_i.err};
              if (cmd_i.last) wptr_d = '0;
            end
          endcase
        end
      end
      BK_COPY: begin
        if (en) begin
          re = (remain_q != 10'd0);
          pend_d = re;
          if (re) begin
            rptr_d = inc(rptr_q); remain_d = remain_q - 10'd1;
          end
          if (pend_q) begin
            we = 1'b1; wptr_d = inc(wptr_q);
            if (fin || cnt_q == 3'd7) begin
              ov_d = 1'b1;
              out_d = '{data_word: word_nx, byte_count: {1'b0, cnt_q} + 4'd1,
                        run_last: fin, stream_done: fin && last_q, error_code: ErrNone};
              word_d = '0; cnt_d = '0;
            end else begin
              word_d = word_nx; cnt_d = cnt_q + 3'd1;
            end
            if (fin && last_q) wptr_d = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk_i) begin
    if (re) rd_q <= (we && waddr == rptr_q) ? wdata : mem[rptr_q];
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d; word_q <= word_d; rptr_q <= rptr_d; last_q <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE; wptr_q <= '0; remain_q <= '0; pend_q <= 1'b0;
      cnt_q <= '0; ov_q <= 1'b0;
    end else begin
      state_q <= state_d; wptr_q <= wptr_d; remain_q <= remain_d; pend_q <= pend_d;
      cnt_q <= cnt_d; ov_q <= ov_d;
    end
  end

endmodule

// File: hw/rtl/lz_flag_uleb_decompressor.sv
// ----------------------------------------------------------------------------
// lz_flag_uleb_decompressor
// LZ decompressor: flag bytes select literals or ULEB128 distance/length copies.
// ----------------------------------------------------------------------------
// Input channel: one compressed byte per request, stream_last on the final one.
// Output channel: one request per result word of up to eight bytes, first byte
// in bits 7:0; run_last marks the last word caused by one input byte, and
// errors come as a single word with byte_count 0 and the error code.
// Flag bytes and unfinished ULEB fields give no output.
// The parser takes one byte per cycle while its two-entry command queue has
// room. The copy engine runs one command at a time; a copy is bounded by the
// single read port of the history memory (one byte read per cycle while the
// output is not stalled). A literal or an error result is registered in the
// command queue and then in the output register. A stalled output freezes
// the copy engine; the queue then fills and the input stalls. Reset clears
// control state but the copy read pointer and last flag; the history memory
// is not cleared, as distances are checked against the bytes produced.
// ----------------------------------------------------------------------------
module lz_flag_uleb_decompressor #(
  parameter int unsigned HISTORY_DEPTH = lzfu_pkg::HistoryDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  lzfu_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lzfu_pkg::out_req_t out_req_o
);
  import lzfu_pkg::*;

  logic push, full, pop, qv;
  cmd_t cmd_in, cmd_out;

  lzfu_front #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_req_i,
    .q_full_i(full), .push_o(push), .cmd_o(cmd_in)
  );

  lzfu_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .cmd_i(cmd_in), .full_o(full),
    .pop_i(pop), .valid_o(qv), .cmd_o(cmd_out)
  );

  lzfu_back #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_back (
    .clk_i, .rst_ni, .q_valid_i(qv), .cmd_i(cmd_out), .pop_o(pop),
    .out_valid_o, .out_stall_i, .out_req_o
  );

endmodule

// File: hw/rtl/lzfu_checker.sv
// ----------------------------------------------------------------------------
// lzfu_checker
// Port-level checks for the decompressor, bound to the top level.
// ----------------------------------------------------------------------------
module lzfu_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_stall_i,
  input lzfu_pkg::out_req_t out_req_i
);
  import lzfu_pkg::*;

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i) else $error("valid dropped");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> $stable(out_req_i)) else $error("request changed");

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_req_i.byte_count <= 4'd8) else $error("bad byte count");

  a_err_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_req_i.error_code != ErrNone |->
      out_req_i.byte_count == 4'd0 && out_req_i.run_last) else $error("bad error word");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_req_i.stream_done |-> out_req_i.run_last)
    else $error("done without run_last");

endmodule

bind lz_flag_uleb_decompressor lzfu_checker u_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .out_valid_i(out_valid_o),
  .out_stall_i(out_stall_i), .out_req_i(out_req_o)
);
